FILE: hdl/ahash_pkg.sv
`default_nettype none
package ahash_pkg;

    localparam int MAX_PIXELS = 64;
    localparam int PIXEL_BITS = 8;
    localparam int IDX_W      = $clog2(MAX_PIXELS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int SUM_W      = PIXEL_BITS + IDX_W;
    localparam int SIDE_W     = 4;
    localparam int MEAN_W     = 8;
    localparam int HASH_W     = 64;

    typedef enum logic [4:0] {
        S_LOAD  = 5'b00001,
        S_DIV   = 5'b00010,
        S_THR   = 5'b00100,
        S_DRAIN = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

endpackage
`default_nettype wire

FILE: hdl/ahash_div.sv
`default_nettype none
module ahash_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [ahash_pkg::SUM_W-1:0] dividend,
    input  wire logic [ahash_pkg::CNT_W-1:0] divisor,
    output logic                             done,
    output logic [ahash_pkg::SUM_W-1:0]      quotient
);
    import ahash_pkg::*;

    localparam int BC_W = $clog2(SUM_W);

    logic              busy_reg;
    logic              done_reg;
    logic [BC_W-1:0]   bit_cnt_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  dvs_reg;
    logic [SUM_W-1:0]  quo_reg;
    logic [CNT_W:0]    trial;
    logic              q_bit;
    logic [CNT_W:0]    diff;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        trial = {rem_reg, quo_reg[SUM_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        q_bit = (trial >= {1'b0, dvs_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            bit_cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg    <= 1'b1;
                bit_cnt_reg <= '0;
            end
            else if (busy_reg)
            begin
                bit_cnt_reg <= bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == BC_W'(SUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[SUM_W-2:0], q_bit};
            rem_reg <= q_bit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

FILE: hdl/average_hash_from_thumbnail_top.sv
// Pixels load at one item per cycle while collecting a thumbnail of N pixels.
// After the last pixel: bit-serial division of the pixel sum by the count, then the mean is taken,
// then the pixel memory is read for the threshold pass; the result is registered
// after the drain state, later while the previous one waits on m_tready.
// No pixels are taken meanwhile: s_tready is high only while loading.
// rst_n is asynchronous, active low: side 8, sums and counts zero.
`default_nettype none
module average_hash_from_thumbnail_top (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [ahash_pkg::SIDE_W-1:0] cfg_wdata,   // side_length
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [7:0]                   s_tdata,     // pixel[7:0]
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [71:0]                       m_tdata      // hash[63:0], mean_level[71:64]
);
    import ahash_pkg::*;

    state_t                 state_reg;
    logic [SIDE_W-1:0]      side_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [IDX_W-1:0]       rd_idx_reg;
    logic                   rd_vld_reg;
    logic [PIXEL_BITS-1:0]  rd_data_reg;
    logic [MEAN_W-1:0]      mean_reg;
    logic [HASH_W-1:0]      hash_reg;
    logic                   out_valid_reg;
    logic [HASH_W-1:0]      out_hash_reg;
    logic [MEAN_W-1:0]      out_mean_reg;

    logic [PIXEL_BITS-1:0]  pixel_store [MAX_PIXELS];

    logic [2*SIDE_W-1:0]    square;
    logic [CNT_W-1:0]       target;
    logic [CNT_W-1:0]       count_next;
    logic [SUM_W-1:0]       sum_next;
    logic [PIXEL_BITS-1:0]  pix;
    logic                   accept;
    logic                   last_pix;
    logic                   div_done;
    logic [SUM_W-1:0]       quotient;
    logic                   out_free;

    always_comb
    begin
        square = side_reg * side_reg;
        if (square == '0)
            target = CNT_W'(1);
        else if (square > (2*SIDE_W)'(MAX_PIXELS))
            target = CNT_W'(MAX_PIXELS);
        else
            target = square[CNT_W-1:0];
        pix        = s_tdata[PIXEL_BITS-1:0];
        accept     = s_tvalid && s_tready;
        count_next = count_reg + 1'b1;
        sum_next   = sum_reg + SUM_W'(pix);
        last_pix   = (count_next >= target);
        out_free   = !out_valid_reg || m_tready;
    end

    assign s_tready = (state_reg == S_LOAD);

    ahash_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept && last_pix),
        .dividend (sum_next),
        .divisor  (count_next),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            side_reg      <= SIDE_W'(8);
            count_reg     <= '0;
            sum_reg       <= '0;
            idx_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (m_tready)
                out_valid_reg <= 1'b0;
            rd_vld_reg <= 1'b0;
            if (cfg_we)
            begin
                side_reg  <= cfg_wdata;
                count_reg <= '0;
                sum_reg   <= '0;
            end
            unique case (state_reg)
                S_LOAD:
                begin
                    if (accept)
                    begin
                        count_reg <= count_next;
                        sum_reg   <= sum_next;
                        if (last_pix)
                            state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    idx_reg <= '0;
                    if (div_done)
                        state_reg <= S_THR;
                end
                S_THR:
                begin
                    rd_vld_reg <= 1'b1;
                    idx_reg    <= idx_reg + 1'b1;
                    if ({1'b0, idx_reg} == count_reg - 1'b1)
                        state_reg <= S_DRAIN;
                end
                S_DRAIN:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        count_reg     <= '0;
                        sum_reg       <= '0;
                        state_reg     <= S_LOAD;
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            pixel_store[count_reg[IDX_W-1:0]] <= pix;
        rd_data_reg <= pixel_store[idx_reg];
        rd_idx_reg  <= idx_reg;
    end

    always_ff @(posedge clk)
    begin
        if (div_done)
        begin
            mean_reg <= quotient[MEAN_W-1:0];
            hash_reg <= '0;
        end
        else if (rd_vld_reg)
            hash_reg[rd_idx_reg] <= (rd_data_reg > mean_reg);
        if (state_reg == S_DONE && out_free)
        begin
            out_hash_reg <= hash_reg;
            out_mean_reg <= mean_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_mean_reg, out_hash_reg};

endmodule
`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import ahash_pkg::*;

    localparam int SETTLE_CYCLES = 120;
    localparam int RANDOM_PIXELS = 1550;

    typedef enum logic {
        ROW_PIX,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic        typed;
        logic [7:0]  value;
        logic [63:0] hash;
        logic [7:0]  mean;
    } stim_row_t;

    typedef struct packed {
        logic [63:0] hash;
        logic [7:0]  mean;
    } hash_result_t;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [SIDE_W-1:0]   cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [71:0]         m_tdata;

    average_hash_from_thumbnail_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // thumbnail model state
    logic [7:0]        thumb_store [0:MAX_PIXELS-1];
    logic [13:0]       level_sum   = '0;
    logic [6:0]        pixel_count = '0;
    logic [SIDE_W-1:0] side_cfg    = 4'd8;

    hash_result_t pending_hashes [$];
    int           mismatches = 0;
    int           burst_left = 0;
    int           rx_mode    = 0;
    int           rx_left    = 0;

    // partial thumbnails ahead of a side write are dropped
    stim_row_t dir_rows [24] = '{
        '{ROW_PIX, 1'b0, 8'd10,  64'h0, 8'd0},
        '{ROW_PIX, 1'b0, 8'd20,  64'h0, 8'd0},
        '{ROW_CFG, 1'b0, 8'd1,   64'h0, 8'd0},
        '{ROW_PIX, 1'b1, 8'd255, 64'h0, 8'd255},
        '{ROW_PIX, 1'b1, 8'd0,   64'h0, 8'd0},
        '{ROW_CFG, 1'b0, 8'd0,   64'h0, 8'd0},
        '{ROW_PIX, 1'b1, 8'd7,   64'h0, 8'd7},
        '{ROW_CFG, 1'b0, 8'd2,   64'h0, 8'd0},
        '{ROW_PIX, 1'b0, 8'd0,   64'h0, 8'd0},
        '{ROW_PIX, 1'b0, 8'd255, 64'h0, 8'd0},
        '{ROW_PIX, 1'b0, 8'd255, 64'h0, 8'd0},
        '{ROW_PIX, 1'b1, 8'd255, 64'hE, 8'd191},
        '{ROW_PIX, 1'b0, 8'd1,   64'h0, 8'd0},
        '{ROW_PIX, 1'b0, 8'd2,   64'h0, 8'd0},
        '{ROW_CFG, 1'b0, 8'd3,   64'h0, 8'd0},
        '{ROW_PIX, 1'b0, 8'h55,  64'h0, 8'd0},
        '{ROW_PIX, 1'b0, 8'hAA,  64'h0, 8'd0},
        '{ROW_PIX, 1'b0, 8'h0F,  64'h0, 8'd0},
        '{ROW_PIX, 1'b0, 8'hF0,  64'h0, 8'd0},
        '{ROW_PIX, 1'b0, 8'h80,  64'h0, 8'd0},
        '{ROW_PIX, 1'b0, 8'h7F,  64'h0, 8'd0},
        '{ROW_PIX, 1'b0, 8'h01,  64'h0, 8'd0},
        '{ROW_PIX, 1'b0, 8'hFE,  64'h0, 8'd0},
        '{ROW_PIX, 1'b0, 8'h33,  64'h0, 8'd0}
    };

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int thumb_pixels(input logic [SIDE_W-1:0] s);
        int n;
        n = int'(s) * int'(s);
        if (n == 0)
            n = 1;
        if (n > MAX_PIXELS)
            n = MAX_PIXELS;
        return n;
    endfunction

    function automatic bit hash_step(input logic [7:0] px, output hash_result_t res);
        int          target;
        logic [13:0] avg;
        target = thumb_pixels(side_cfg);
        res = '0;
        if (pixel_count >= 7'(MAX_PIXELS))
        begin
            level_sum = '0;
            pixel_count = '0;
        end
        thumb_store[pixel_count[5:0]] = px;
        level_sum = level_sum + 14'(px);
        pixel_count = pixel_count + 7'd1;
        if (int'(pixel_count) < target)
            return 1'b0;
        avg = level_sum / 14'(pixel_count);
        for (int i = 0; i < int'(pixel_count); i++)
        begin
            if (14'(thumb_store[i]) > avg)
                res.hash[i] = 1'b1;
        end
        res.mean = avg[7:0];
        level_sum = '0;
        pixel_count = '0;
        return 1'b1;
    endfunction

    function automatic logic [7:0] pick_level(input int mode, input logic [7:0] base);
        int v;
        case (mode)
            0: v = $urandom_range(0, 255);
            1: v = base;
            2: v = $urandom_range(0, 1) ? 255 : 0;
            3:
            begin
                v = int'(base) + $urandom_range(0, 6) - 3;
                if (v < 0)
                    v = 0;
                if (v > 255)
                    v = 255;
            end
            default: v = (base == 8'hFF) ? base - $urandom_range(0, 1) : base + $urandom_range(0, 1);
        endcase
        return 8'(v);
    endfunction

    task automatic send_pixel(input logic [7:0] px, input logic typed,
                              input logic [63:0] t_hash, input logic [7:0] t_mean);
        hash_result_t res;
        bit           got;
        int           gap;
        s_tdata <= px;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        got = hash_step(px, res);
        if (typed)
            pending_hashes.push_back({t_hash, t_mean});
        else if (got)
            pending_hashes.push_back(res);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic set_side(input logic [SIDE_W-1:0] s);
        s_tvalid <= 1'b0;
        while (pending_hashes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wdata <= s;
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        side_cfg = s;
        level_sum = '0;
        pixel_count = '0;
        burst_left = 0;
    endtask

    // receiver stall pattern
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(8, 80);
        end
        else
            rx_left--;
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        hash_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_hashes.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected item hash %h mean %0d", $time,
                         m_tdata[63:0], m_tdata[71:64]);
            end
            else
            begin
                want = pending_hashes.pop_front();
                if (m_tdata[63:0] !== want.hash)
                begin
                    mismatches++;
                    $display("%0t: hash expected %h actual %h", $time, want.hash,
                             m_tdata[63:0]);
                end
                if (m_tdata[71:64] !== want.mean)
                begin
                    mismatches++;
                    $display("%0t: mean expected %0d actual %0d", $time, want.mean,
                             m_tdata[71:64]);
                end
            end
        end
    end

    initial
    begin
        int          sent;
        int          phase;
        int          npix;
        int          nthumb;
        int          mode;
        int          cut;
        logic [7:0]  base;
        logic [SIDE_W-1:0] s;
        sent = 0;
        phase = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[r])
        begin
            if (dir_rows[r].kind == ROW_CFG)
                set_side(dir_rows[r].value[SIDE_W-1:0]);
            else
                send_pixel(dir_rows[r].value, dir_rows[r].typed, dir_rows[r].hash,
                           dir_rows[r].mean);
        end

        while (sent < RANDOM_PIXELS)
        begin
            case (phase)
                0: s = 4'd8;
                1: s = 4'd15;
                2: s = 4'd0;
                3: s = 4'd1;
                default: s = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 5))
                                                        : 4'($urandom_range(6, 15));
            endcase
            set_side(s);
            npix = thumb_pixels(s);
            nthumb = (npix >= 36) ? $urandom_range(1, 2) : $urandom_range(2, 12);
            for (int t = 0; t < nthumb; t++)
            begin
                mode = $urandom_range(0, 4);
                base = 8'($urandom_range(0, 255));
                for (int k = 0; k < npix; k++)
                    send_pixel(pick_level(mode, base), 1'b0, '0, '0);
                sent += npix;
            end
            // dropped partial thumbnail
            if (npix > 1 && $urandom_range(0, 3) == 0)
            begin
                cut = $urandom_range(1, npix - 1);
                for (int k = 0; k < cut; k++)
                    send_pixel(8'($urandom_range(0, 255)), 1'b0, '0, '0);
            end
            phase++;
        end

        s_tvalid <= 1'b0;
        while (pending_hashes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
`default_nettype wire
